/* rtl/isl_pkg.sv */
package isl_pkg;

    localparam int DEPTH  = 64;
    localparam int WIDTH  = 32;
    localparam int IDX_W  = 6;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 7;
    localparam int QTY_W  = 7;
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;

    typedef logic [WIDTH-1:0] word_t;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_READ   = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_PINCH  = 3'd4
    } op_t;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // Command broadcast to every cell of the row
    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [IDX_W-1:0]  idx;
        logic [CNT_W-1:0]  used;
        word_t             value;
    } cell_cmd_t;

endpackage

/* rtl/isl_cell.sv */
module isl_cell
    import isl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] pos,
    input  cell_cmd_t        cmd,
    input  logic [IDX_W-1:0] sel_idx,
    input  word_t            left_word,
    input  word_t            right_word,
    output word_t            word,
    output word_t            sel_word
);

    word_t            word_reg;
    word_t            word_next;
    logic [CNT_W-1:0] pos_c;
    logic [CNT_W-1:0] idx_c;

    assign pos_c = {1'b0, pos};
    assign idx_c = {1'b0, cmd.idx};

    // Pick the next word: own, new value, left or right neighbor, or zero
    always_comb begin
        word_next = word_reg;
        case (cmd.kind)
            CMD_INSERT: begin
                if (pos == cmd.idx) begin
                    word_next = cmd.value;
                end else if (pos_c > idx_c && pos_c <= cmd.used) begin
                    word_next = left_word;
                end
            end
            CMD_REMOVE: begin
                if (pos_c >= idx_c && (pos_c + CNT_W'(1)) < cmd.used) begin
                    word_next = right_word;
                end
            end
            CMD_CLEAR: begin
                if (pos_c < cmd.used) begin
                    word_next = '0;
                end
            end
            default: begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg <= '0;
        end else begin
            word_reg <= word_next;
        end
    end

    assign word     = word_reg;
    assign sel_word = (pos == sel_idx) ? word_reg : '0;

endmodule

/* rtl/indexed_shift_list.sv */
// Indexed shift list: an ordered list of words kept in a row of DEPTH cells.
// Input words (s_valid/s_ready) carry an op: insert, remove, read, clear or
// pinch a run of entries. Result words (m_valid/m_ready) carry status, data,
// the count after the result, and last on the final result of each input.
// Insert, remove, read and clear act on all cells at once: the input is taken
// and its result is registered, shown on the next cycle.
// A valid pinch of q entries removes one entry per cycle through the cell row
// while the result side is free; with emit it gives q results, one per removed
// word, otherwise one result after the last step.
// A new input word is taken only when no pinch is in progress and the result
// register is empty or being drained in the same cycle, so one input is
// handled at a time, at best one per cycle.
// When the receiver stalls, the result holds and pinch steps wait.
// Reset (aresetn low, synchronous) zeroes every cell and empties the list.
module indexed_shift_list
    import isl_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_op,
    input  logic [IDX_W-1:0]  s_index,
    input  logic [DATA_W-1:0] s_value,
    input  logic [QTY_W-1:0]  s_quantity,
    input  logic              s_emit,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAT_W-1:0] m_status,
    output logic [DATA_W-1:0] m_data,
    output logic [CNT_W-1:0]  m_count,
    output logic              m_last
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_PINCH = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [IDX_W-1:0]  pinch_idx_reg, pinch_idx_next;
    logic [QTY_W-1:0]  left_reg, left_next;
    logic              emit_reg, emit_next;
    logic              m_valid_reg, m_valid_next;
    logic [STAT_W-1:0] m_status_reg, m_status_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    logic [CNT_W-1:0]  m_count_reg, m_count_next;
    logic              m_last_reg, m_last_next;

    cell_cmd_t         cmd;
    word_t             words     [DEPTH];
    word_t             sel_words [DEPTH];
    word_t             sel_any;
    logic [IDX_W-1:0]  sel_idx;
    logic              out_free;
    logic              accept;
    logic [CNT_W-1:0]  idx_c;
    logic [CNT_W:0]    run_end;

    // Point at the pinch position while a run is stepping, else at the input
    assign sel_idx = (state_reg == ST_PINCH) ? pinch_idx_reg : s_index;

    // Row of cells, each shifting from its neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        word_t left_w;
        word_t right_w;
        if (g == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_left
            assign left_w = words[g-1];
        end
        if (g == DEPTH - 1) begin : g_final
            assign right_w = '0;
        end else begin : g_right
            assign right_w = words[g+1];
        end
        isl_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .pos        (IDX_W'(g)),
            .cmd        (cmd),
            .sel_idx    (sel_idx),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (words[g]),
            .sel_word   (sel_words[g])
        );
    end

    // Merge the selected cell's word
    always_comb begin
        sel_any = '0;
        for (int i = 0; i < DEPTH; i++) begin
            sel_any = sel_any | sel_words[i];
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign idx_c    = {1'b0, s_index};
    assign run_end  = {2'b00, s_index} + {1'b0, s_quantity};

    // Control: decode ops, step pinch runs, load the result register
    always_comb begin
        state_next     = state_reg;
        used_next      = used_reg;
        pinch_idx_next = pinch_idx_reg;
        left_next      = left_reg;
        emit_next      = emit_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_data_next    = m_data_reg;
        m_count_next   = m_count_reg;
        m_last_next    = m_last_reg;

        cmd.kind  = CMD_HOLD;
        cmd.idx   = sel_idx;
        cmd.used  = used_reg;
        cmd.value = WIDTH'(s_value);

        if (state_reg == ST_PINCH) begin
            if (out_free) begin
                cmd.kind  = CMD_REMOVE;
                used_next = used_reg - CNT_W'(1);
                left_next = left_reg - QTY_W'(1);
                if (emit_reg || left_reg == QTY_W'(1)) begin
                    m_valid_next  = 1'b1;
                    m_status_next = STAT_OK;
                    m_data_next   = emit_reg ? DATA_W'(sel_any) : '0;
                    m_count_next  = used_reg - CNT_W'(1);
                    m_last_next   = (left_reg == QTY_W'(1));
                end
                if (left_reg == QTY_W'(1)) begin
                    state_next = ST_IDLE;
                end
            end
        end else if (accept) begin
            m_valid_next  = 1'b1;
            m_status_next = STAT_OK;
            m_data_next   = '0;
            m_count_next  = used_reg;
            m_last_next   = 1'b1;
            case (op_t'(s_op))
                OP_INSERT: begin
                    if (idx_c >= CNT_W'(DEPTH)) begin
                        m_status_next = STAT_RANGE;
                    end else if (used_reg >= CNT_W'(DEPTH)) begin
                        m_status_next = STAT_FULL;
                    end else begin
                        cmd.kind     = CMD_INSERT;
                        used_next    = (idx_c >= used_reg) ? idx_c + CNT_W'(1)
                                                           : used_reg + CNT_W'(1);
                        m_count_next = used_next;
                    end
                end
                OP_REMOVE: begin
                    if (idx_c >= used_reg) begin
                        m_status_next = STAT_RANGE;
                    end else begin
                        cmd.kind     = CMD_REMOVE;
                        used_next    = used_reg - CNT_W'(1);
                        m_count_next = used_next;
                    end
                end
                OP_READ: begin
                    if (idx_c >= used_reg) begin
                        m_status_next = STAT_RANGE;
                    end else begin
                        m_data_next = DATA_W'(sel_any);
                    end
                end
                OP_CLEAR: begin
                    cmd.kind     = CMD_CLEAR;
                    used_next    = '0;
                    m_count_next = '0;
                end
                OP_PINCH: begin
                    if (s_quantity == '0) begin
                        m_status_next = STAT_OK;
                    end else if (idx_c >= used_reg || run_end > {1'b0, used_reg}) begin
                        m_status_next = STAT_RANGE;
                    end else begin
                        // hold the result slot empty until the first step
                        m_valid_next   = 1'b0;
                        state_next     = ST_PINCH;
                        pinch_idx_next = s_index;
                        left_next      = s_quantity;
                        emit_next      = s_emit;
                    end
                end
                default: begin
                    m_status_next = STAT_RANGE;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pinch_idx_reg <= pinch_idx_next;
        left_reg      <= left_next;
        emit_reg      <= emit_next;
        m_status_reg  <= m_status_next;
        m_data_reg    <= m_data_next;
        m_count_reg   <= m_count_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_data   = m_data_reg;
    assign m_count  = m_count_reg;
    assign m_last   = m_last_reg;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import isl_pkg::*;

    localparam int ITEM_TOTAL    = 330;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int IDLE_PCT      = 14;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] value;
        logic [QTY_W-1:0]  quantity;
        logic              emit;
        logic              drain;
    } list_cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  count;
        logic              last;
    } list_reply_t;

    logic              aclk       = 1'b0;
    logic              aresetn    = 1'b0;
    logic              s_valid    = 1'b0;
    logic              s_ready;
    logic [OP_W-1:0]   s_op       = '0;
    logic [IDX_W-1:0]  s_index    = '0;
    logic [DATA_W-1:0] s_value    = '0;
    logic [QTY_W-1:0]  s_quantity = '0;
    logic              s_emit     = 1'b0;
    logic              m_valid;
    logic              m_ready    = 1'b0;
    logic [STAT_W-1:0] m_status;
    logic [DATA_W-1:0] m_data;
    logic [CNT_W-1:0]  m_count;
    logic              m_last;

    list_cmd_t   cmd_q [$];
    list_reply_t reply_q [$];

    // Shadow copy of the list
    word_t list_mem [DEPTH];
    int    list_len;

    // Fill estimate used only to shape stimulus
    int gen_fill;

    int sent_cnt  = 0;
    int took_cnt  = 0;
    int rx_cnt    = 0;
    int err_cnt   = 0;
    int cycle_cnt = 0;

    indexed_shift_list u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_index    (s_index),
        .s_value    (s_value),
        .s_quantity (s_quantity),
        .s_emit     (s_emit),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_data     (m_data),
        .m_count    (m_count),
        .m_last     (m_last)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    task automatic note_mismatch(string fld, logic [31:0] got, logic [31:0] want);
        err_cnt++;
        $display("mismatch %s at result %0d: got %0h want %0h", fld, rx_cnt, got, want);
    endtask

    task automatic post_reply(logic [STAT_W-1:0] st, logic [DATA_W-1:0] d, logic lst);
        list_reply_t r;
        r.status = st;
        r.data   = d;
        r.count  = CNT_W'(list_len);
        r.last   = lst;
        reply_q.push_back(r);
    endtask

    // Close the hole at one position; the top entry keeps its stale word
    task automatic drop_entry(int at);
        for (int k = at; k + 1 < list_len; k++) begin
            list_mem[k] = list_mem[k + 1];
        end
        list_len--;
    endtask

    // Apply one accepted command to the shadow list and queue its replies
    task automatic predict_list_op(list_cmd_t c);
        int    idx;
        int    qty;
        word_t taken;
        idx = int'(c.index);
        qty = int'(c.quantity);
        case (c.op)
            OP_INSERT: begin
                if (idx >= DEPTH) begin
                    post_reply(STAT_RANGE, '0, 1'b1);
                end else if (list_len >= DEPTH) begin
                    post_reply(STAT_FULL, '0, 1'b1);
                end else begin
                    if (idx >= list_len) begin
                        list_len = idx + 1;
                    end else begin
                        for (int k = list_len; k > idx; k--) begin
                            list_mem[k] = list_mem[k - 1];
                        end
                        list_len++;
                    end
                    list_mem[idx] = c.value[WIDTH-1:0];
                    post_reply(STAT_OK, '0, 1'b1);
                end
            end
            OP_REMOVE: begin
                if (idx >= list_len) begin
                    post_reply(STAT_RANGE, '0, 1'b1);
                end else begin
                    drop_entry(idx);
                    post_reply(STAT_OK, '0, 1'b1);
                end
            end
            OP_READ: begin
                if (idx >= list_len) begin
                    post_reply(STAT_RANGE, '0, 1'b1);
                end else begin
                    post_reply(STAT_OK, DATA_W'(list_mem[idx]), 1'b1);
                end
            end
            OP_CLEAR: begin
                for (int k = 0; k < list_len && k < DEPTH; k++) begin
                    list_mem[k] = '0;
                end
                list_len = 0;
                post_reply(STAT_OK, '0, 1'b1);
            end
            OP_PINCH: begin
                if (qty == 0) begin
                    post_reply(STAT_OK, '0, 1'b1);
                end else if (idx >= list_len || idx + qty > list_len) begin
                    post_reply(STAT_RANGE, '0, 1'b1);
                end else if (c.emit) begin
                    for (int k = 0; k < qty; k++) begin
                        taken = list_mem[idx];
                        drop_entry(idx);
                        post_reply(STAT_OK, DATA_W'(taken), k + 1 == qty);
                    end
                end else begin
                    for (int k = 0; k < qty; k++) begin
                        drop_entry(idx);
                    end
                    post_reply(STAT_OK, '0, 1'b1);
                end
            end
            default: begin
                post_reply(STAT_RANGE, '0, 1'b1);
            end
        endcase
    endtask

    // Queue one command and track the rough fill for later shaping
    task automatic add_cmd(logic [OP_W-1:0] op, int idx, logic [31:0] val, int qty,
                           logic emit, logic drain);
        list_cmd_t c;
        c.op       = op;
        c.index    = IDX_W'(idx);
        c.value    = val;
        c.quantity = QTY_W'(qty);
        c.emit     = emit;
        c.drain    = drain;
        cmd_q.push_back(c);
        case (op)
            OP_INSERT: begin
                if (gen_fill < DEPTH) gen_fill = (idx >= gen_fill) ? idx + 1 : gen_fill + 1;
            end
            OP_REMOVE: begin
                if (idx < gen_fill) gen_fill--;
            end
            OP_CLEAR: begin
                gen_fill = 0;
            end
            OP_PINCH: begin
                if (qty > 0 && idx < gen_fill && idx + qty <= gen_fill) gen_fill -= qty;
            end
            default: ;
        endcase
    endtask

    // Drive input words at the falling edge; hold until the word is taken
    always @(negedge aclk) begin
        list_cmd_t c;
        logic      go;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && sent_cnt != took_cnt)) begin
            go = cmd_q.size() != 0;
            if (go && cmd_q[0].drain && reply_q.size() != 0) go = 1'b0;
            if (go && !(sent_cnt >= 140 && sent_cnt < 220) &&
                $urandom_range(99) < IDLE_PCT) go = 1'b0;
            if (go) begin
                c = cmd_q.pop_front();
                sent_cnt++;
                s_valid    <= 1'b1;
                s_op       <= c.op;
                s_index    <= c.index;
                s_value    <= c.value;
                s_quantity <= c.quantity;
                s_emit     <= c.emit;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random, with one steady stretch
    always @(negedge aclk) begin
        if (rx_cnt >= 150 && rx_cnt < 400) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= $urandom_range(99) >= IDLE_PCT;
        end
    end

    // Predict on each accepted input word, check each accepted result word
    always @(posedge aclk) begin
        list_cmd_t   c;
        list_reply_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                c.op       = s_op;
                c.index    = s_index;
                c.value    = s_value;
                c.quantity = s_quantity;
                c.emit     = s_emit;
                c.drain    = 1'b0;
                predict_list_op(c);
                took_cnt++;
            end
            if (m_valid && m_ready) begin
                if (reply_q.size() == 0) begin
                    note_mismatch("unexpected word", m_data, '0);
                end else begin
                    want = reply_q.pop_front();
                    if (m_status !== want.status) begin
                        note_mismatch("status", 32'(m_status), 32'(want.status));
                    end
                    if (m_data !== want.data) note_mismatch("data", m_data, want.data);
                    if (m_count !== want.count) begin
                        note_mismatch("count", 32'(m_count), 32'(want.count));
                    end
                    if (m_last !== want.last) begin
                        note_mismatch("last", 32'(m_last), 32'(want.last));
                    end
                end
                rx_cnt++;
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int           roll;
        int           idx;
        int           qty;
        int           span;
        logic         drain;
        logic [31:0]  val;

        for (int i = 0; i < DEPTH; i++) begin
            list_mem[i] = '0;
        end
        list_len = 0;
        gen_fill = 0;

        // Empty list: out-of-range read, remove and pinch; empty pinch is fine
        add_cmd(OP_READ,   0, 32'h0, 0, 1'b0, 1'b0);
        add_cmd(OP_REMOVE, 0, 32'h0, 0, 1'b0, 1'b0);
        add_cmd(OP_PINCH,  0, 32'h0, 0, 1'b1, 1'b0);
        add_cmd(OP_PINCH,  0, 32'h0, 1, 1'b1, 1'b0);
        // Unknown ops
        add_cmd(3'd5, 0,  32'hFFFF_FFFF, 127, 1'b1, 1'b0);
        add_cmd(3'd6, 63, 32'h0, 0, 1'b0, 1'b0);
        add_cmd(3'd7, 21, 32'h1234_5678, 64, 1'b1, 1'b0);
        // Insert at head, then past the end over a gap
        add_cmd(OP_INSERT, 0, 32'hFFFF_FFFF, 0, 1'b0, 1'b0);
        add_cmd(OP_INSERT, 0, 32'h0000_0000, 0, 1'b0, 1'b0);
        add_cmd(OP_INSERT, 5, 32'hA5A5_A5A5, 0, 1'b0, 1'b0);
        add_cmd(OP_READ,   3, 32'h0, 0, 1'b0, 1'b0);
        add_cmd(OP_READ,   5, 32'h0, 0, 1'b0, 1'b0);
        add_cmd(OP_READ,   6, 32'h0, 0, 1'b0, 1'b0);
        // Remove the last entry, then pinch a run out with emit
        add_cmd(OP_REMOVE, 5, 32'h0, 0, 1'b0, 1'b0);
        add_cmd(OP_PINCH,  1, 32'h0, 3, 1'b1, 1'b0);
        add_cmd(OP_PINCH,  0, 32'h0, 127, 1'b1, 1'b0);
        // Fill to the top through a gap, then hit the full case
        add_cmd(OP_INSERT, 63, 32'h1234_5678, 0, 1'b0, 1'b0);
        add_cmd(OP_INSERT, 0,  32'h5A5A_5A5A, 0, 1'b0, 1'b0);
        add_cmd(OP_READ,   63, 32'h0, 0, 1'b0, 1'b0);
        // Pinch the whole list with emit, after a full pause
        add_cmd(OP_PINCH,  0, 32'h0, 64, 1'b1, 1'b1);
        // Stale contents show up in a new gap
        add_cmd(OP_INSERT, 10, 32'hDEAD_BEEF, 0, 1'b0, 1'b0);
        add_cmd(OP_READ,   4,  32'h0, 0, 1'b0, 1'b0);
        add_cmd(OP_PINCH,  2,  32'h0, 5, 1'b0, 1'b0);
        // Clear zeroes the used entries
        add_cmd(OP_CLEAR,  0, 32'h0, 0, 1'b0, 1'b0);
        add_cmd(OP_INSERT, 3, 32'h5555_5555, 0, 1'b0, 1'b0);
        add_cmd(OP_READ,   1, 32'h0, 0, 1'b0, 1'b0);

        // Random part: mostly in-range commands, some noise
        for (int n = 0; n < ITEM_TOTAL; n++) begin
            roll  = $urandom_range(99);
            drain = (n == 80 || n == 220);
            val   = $urandom();
            qty   = $urandom_range(127);
            if (gen_fill == DEPTH && $urandom_range(3) == 0) begin
                add_cmd(OP_CLEAR, $urandom_range(63), val, qty, 1'($urandom_range(1)), drain);
            end else if (roll < 34) begin
                if ($urandom_range(9) == 0 || gen_fill >= 63) idx = $urandom_range(63);
                else idx = $urandom_range(gen_fill);
                add_cmd(OP_INSERT, idx, val, qty, 1'($urandom_range(1)), drain);
            end else if (roll < 46 || roll < 66) begin
                if (gen_fill > 0 && $urandom_range(7) != 0) idx = $urandom_range(gen_fill - 1);
                else idx = $urandom_range(63);
                add_cmd(roll < 46 ? OP_REMOVE : OP_READ, idx, val, qty,
                        1'($urandom_range(1)), drain);
            end else if (roll < 84) begin
                if (gen_fill > 0 && $urandom_range(7) != 0) begin
                    idx  = $urandom_range(gen_fill - 1);
                    span = gen_fill - idx;
                    if ($urandom_range(9) == 0) qty = span;
                    else qty = 1 + $urandom_range(span > 4 ? 3 : span - 1);
                end else begin
                    idx = $urandom_range(63);
                end
                add_cmd(OP_PINCH, idx, val, qty, 1'($urandom_range(1)), drain);
            end else if (roll < 87) begin
                add_cmd(OP_CLEAR, $urandom_range(63), val, qty, 1'($urandom_range(1)), drain);
            end else if (roll < 90) begin
                add_cmd(OP_W'($urandom_range(7, 5)), $urandom_range(63), val, qty,
                        1'($urandom_range(1)), drain);
            end else begin
                add_cmd(OP_W'($urandom_range(4)), $urandom_range(63), val, qty,
                        1'($urandom_range(1)), drain);
            end
        end

        // Hold reset, then release it at a falling edge
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (cmd_q.size() != 0 || took_cnt != sent_cnt) @(posedge aclk);
        while (reply_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
